[hdl/jpp_pkg.sv]
// Shared constants and types for the JSON pretty printer.
`timescale 1ns / 1ps

package jpp_pkg;

    // Default nesting limit handed to the top level.
    localparam int JPP_MAX_DEPTH_DEFAULT = 15;

    // The widest indentation step; wider register values act as this.
    localparam int JPP_INDENT_MAX = 4;

    localparam logic [2:0] JPP_INDENT_RESET = 3'd2;

    // Character codes.
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_LBRACK = 8'h5B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;
    localparam logic [7:0] CH_RBRACK = 8'h5D;
    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_LF     = 8'h0A;

    // Bytes still owed for the transaction being expanded, in emission order:
    // a leading line break, the indentation (counted separately), the input
    // byte itself, then a trailing space or a trailing line break.
    typedef struct packed {
        logic pre_cr;
        logic pre_lf;
        logic main_pend;
        logic suf_sp;
        logic suf_cr;
        logic suf_lf;
    } plan_flags_t;

endpackage

[hdl/json_pretty_printer_core.sv]
// JSON pretty printer: expands compact JSON bytes into indented text.
// An accepted input byte is registered into the expansion plan, and its output bytes then pass
// through the output register. Throughput: one output byte per cycle while m_ready is high,
// limited by the single output register; an input transaction emits from 1 up to
// MAX_DEPTH * 4 + 3 bytes. Reset (aresetn low, synchronous) empties both stages, clears the
// parser state and sets the indentation width to 2.
`timescale 1ns / 1ps

module json_pretty_printer_core #(
    parameter int MAX_DEPTH = jpp_pkg::JPP_MAX_DEPTH_DEFAULT
) (
    input  logic       aclk,
    input  logic       aresetn,

    input  logic       cfg_wr_en,
    input  logic [2:0] cfg_wr_data,

    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_in_byte,

    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_out_byte,
    output logic       m_last
);

    import jpp_pkg::*;

    // The nesting depth only needs to reach MAX_DEPTH, and the indentation run is at most
    // MAX_DEPTH levels of the widest step.
    localparam int NestWidth = $clog2(MAX_DEPTH + 1);
    localparam int CntWidth  = $clog2(MAX_DEPTH * JPP_INDENT_MAX + 1);

    // ------------------------------------------------------------------------------------
    // Configuration and parser state. The parser state advances when an input transaction
    // is accepted, so the next byte sees it right away.
    // ------------------------------------------------------------------------------------
    logic [2:0]           indent_width_reg;
    logic                 in_string_reg, in_string_next;
    logic [7:0]           prev_byte_reg;
    logic [NestWidth-1:0] nest_reg, nest_next;
    logic                 line_start_reg, line_start_next;

    // Expansion plan of the transaction being emitted.
    logic                 plan_valid_reg;
    plan_flags_t          plan_reg, plan_next;
    logic [CntWidth-1:0]  indent_cnt_reg, indent_cnt_next;
    logic [7:0]           main_byte_reg;

    // Output register.
    logic                 m_valid_reg;
    logic [7:0]           m_out_byte_reg;
    logic                 m_last_reg;

    logic                 s_accept;
    logic                 out_load;
    logic                 plan_done;
    plan_flags_t          plan_after;
    logic [CntWidth-1:0]  indent_cnt_after;
    logic [7:0]           out_byte_sel;

    // ------------------------------------------------------------------------------------
    // Decode of the incoming byte into the new state and the list of bytes it produces.
    // ------------------------------------------------------------------------------------
    logic                 after_opener;
    logic                 is_closer;
    logic                 need_break;
    logic                 need_indent;
    logic [2:0]           width_eff;
    logic [CntWidth-1:0]  indent_len;

    assign after_opener = (prev_byte_reg == CH_LBRACE) || (prev_byte_reg == CH_LBRACK);
    assign is_closer    = (s_in_byte == CH_RBRACE) || (s_in_byte == CH_RBRACK);

    always_comb begin
        in_string_next  = in_string_reg;
        nest_next       = nest_reg;
        need_break      = 1'b0;
        plan_next       = '0;
        plan_next.main_pend = 1'b1;
        line_start_next = (s_in_byte == CH_LF);

        if (in_string_reg) begin
            // Only a single preceding backslash is checked, so an escaped backslash
            // right before a quote keeps the string open.
            if ((s_in_byte == CH_QUOTE) && (prev_byte_reg != CH_BSLASH)) begin
                in_string_next = 1'b0;
            end
        end else if (is_closer) begin
            // A closer right after an opener keeps empty blocks on one line.
            if (!after_opener) begin
                need_break = 1'b1;
                if (nest_reg != '0) begin
                    nest_next = nest_reg - 1'b1;
                end
            end
        end else if (s_in_byte == CH_COLON) begin
            plan_next.suf_sp = 1'b1;
            line_start_next  = 1'b0;
        end else if (s_in_byte == CH_COMMA) begin
            plan_next.suf_cr = 1'b1;
            plan_next.suf_lf = 1'b1;
            line_start_next  = 1'b1;
        end else begin
            if (s_in_byte == CH_QUOTE) begin
                in_string_next = 1'b1;
            end
            // The first element of a block goes on a new, deeper line.
            if (after_opener) begin
                need_break = 1'b1;
                if (nest_reg < NestWidth'(MAX_DEPTH)) begin
                    nest_next = nest_reg + 1'b1;
                end
            end
        end

        plan_next.pre_cr = need_break;
        plan_next.pre_lf = need_break;
    end

    // Indentation precedes the input byte whenever a line break came right before it,
    // either one owed from an earlier transaction or the leading break of this one. A
    // leading break itself is never indented.
    assign need_indent = need_break || line_start_reg;
    assign width_eff   = (indent_width_reg > 3'(JPP_INDENT_MAX)) ? 3'(JPP_INDENT_MAX)
                                                                : indent_width_reg;
    assign indent_len  = CntWidth'(nest_next) * CntWidth'(width_eff);
    assign indent_cnt_next = need_indent ? indent_len : '0;

    // ------------------------------------------------------------------------------------
    // Emission: pick the next owed byte and strike it from the plan.
    // ------------------------------------------------------------------------------------
    always_comb begin
        plan_after       = plan_reg;
        indent_cnt_after = indent_cnt_reg;
        out_byte_sel     = main_byte_reg;
        if (plan_reg.pre_cr) begin
            out_byte_sel      = CH_CR;
            plan_after.pre_cr = 1'b0;
        end else if (plan_reg.pre_lf) begin
            out_byte_sel      = CH_LF;
            plan_after.pre_lf = 1'b0;
        end else if (indent_cnt_reg != '0) begin
            out_byte_sel     = CH_SPACE;
            indent_cnt_after = indent_cnt_reg - 1'b1;
        end else if (plan_reg.main_pend) begin
            out_byte_sel         = main_byte_reg;
            plan_after.main_pend = 1'b0;
        end else if (plan_reg.suf_sp) begin
            out_byte_sel      = CH_SPACE;
            plan_after.suf_sp = 1'b0;
        end else if (plan_reg.suf_cr) begin
            out_byte_sel      = CH_CR;
            plan_after.suf_cr = 1'b0;
        end else begin
            out_byte_sel      = CH_LF;
            plan_after.suf_lf = 1'b0;
        end
    end

    assign plan_done = (plan_after == '0) && (indent_cnt_after == '0);

    // The output register takes a byte whenever it is empty or being drained. A new input
    // transaction is taken as soon as the plan is empty or hands over its final byte, so
    // single-byte transactions stream at one per cycle while m_ready is high.
    assign out_load = plan_valid_reg && (!m_valid_reg || m_ready);
    assign s_ready  = !plan_valid_reg || (out_load && plan_done);
    assign s_accept = s_valid && s_ready;

    // ------------------------------------------------------------------------------------
    // Registers.
    // ------------------------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            indent_width_reg <= JPP_INDENT_RESET;
            in_string_reg    <= 1'b0;
            prev_byte_reg    <= '0;
            nest_reg         <= '0;
            line_start_reg   <= 1'b0;
            plan_valid_reg   <= 1'b0;
            m_valid_reg      <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                indent_width_reg <= cfg_wr_data;
            end

            if (s_accept) begin
                in_string_reg  <= in_string_next;
                prev_byte_reg  <= s_in_byte;
                nest_reg       <= nest_next;
                line_start_reg <= line_start_next;
                plan_valid_reg <= 1'b1;
            end else if (out_load && plan_done) begin
                plan_valid_reg <= 1'b0;
            end

            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers need no reset; the valid flags guard them.
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            plan_reg       <= plan_next;
            indent_cnt_reg <= indent_cnt_next;
            main_byte_reg  <= s_in_byte;
        end else if (out_load) begin
            plan_reg       <= plan_after;
            indent_cnt_reg <= indent_cnt_after;
        end

        if (out_load) begin
            m_out_byte_reg <= out_byte_sel;
            m_last_reg     <= plan_done;
        end
    end

    assign m_valid    = m_valid_reg;
    assign m_out_byte = m_out_byte_reg;
    assign m_last     = m_last_reg;

endmodule
